// ===== rtl/core/rpbu_pkg.sv =====
// ----------------------------------------------------------------------------
// rpbu_pkg: shared types and constants of the RGB24 pixel blend unit
// Holds the register codes, the per-lane control bundle and the flag bundle
// that travel between the alpha path, the color lanes and the merge stage.
// ----------------------------------------------------------------------------
package rpbu_pkg;

  // Channel and port widths.
  localparam int unsigned ChanW    = 8;
  localparam int unsigned NumLanes = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // Full-scale channel value.
  localparam logic [ChanW-1:0] ChanMax = 8'hFF;

  // Factor selector codes. Codes above the last member select full scale.
  typedef enum logic [3:0] {
    FacZero        = 4'd0,
    FacOne         = 4'd1,
    FacSrcAlpha    = 4'd2,
    FacInvSrcAlpha = 4'd3,
    FacDstAlpha    = 4'd4,
    FacInvDstAlpha = 4'd5,
    FacSrcColor    = 4'd6,
    FacDstColor    = 4'd7,
    FacInvSrcColor = 4'd8,
    FacInvDstColor = 4'd9
  } factor_e;

  // Blend operation codes. The remaining codes keep the destination.
  typedef enum logic [2:0] {
    OpAdd    = 3'd0,
    OpSub    = 3'd1,
    OpRevSub = 3'd2,
    OpAnd    = 3'd3
  } blend_op_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegSrcFactor   = 3'd0,
    RegDstFactor   = 3'd1,
    RegBlendOp     = 3'd2,
    RegColoringOnly = 3'd3,
    RegTintEnable  = 3'd4,
    RegTintAlpha   = 3'd5,
    RegTintRgb     = 3'd6
  } cfg_idx_e;

  // Control shared by all color lanes.
  typedef struct packed {
    logic      tint_act;
    factor_e   src_factor;
    factor_e   dst_factor;
    blend_op_e blend_op;
  } lane_ctl_t;

  // Load enables of the two lane pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
  } pipe_en_t;

  // Per-pixel flags that reach the merge stage.
  typedef struct packed {
    logic skip;
    logic opaque;
    logic row_end;
  } pix_flags_t;

endpackage

// ===== rtl/core/rpbu_pix_in_if.sv =====
// ----------------------------------------------------------------------------
// rpbu_pix_in_if: pixel input channel
// Valid/ready channel carrying the source color with alpha, the destination
// color and the end-of-row marker.
// ----------------------------------------------------------------------------
interface rpbu_pix_in_if
  import rpbu_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] src_red;
  logic [ChanW-1:0] src_green;
  logic [ChanW-1:0] src_blue;
  logic [ChanW-1:0] src_alpha;
  logic [ChanW-1:0] dst_red;
  logic [ChanW-1:0] dst_green;
  logic [ChanW-1:0] dst_blue;
  logic             row_end;

  modport source (
    output valid, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue, row_end,
    input  ready
  );

  modport sink (
    input  valid, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue, row_end,
    output ready
  );
endinterface

// ===== rtl/core/rpbu_pix_out_if.sv =====
// ----------------------------------------------------------------------------
// rpbu_pix_out_if: pixel output channel
// Valid/ready channel carrying the new destination color and its flags.
// ----------------------------------------------------------------------------
interface rpbu_pix_out_if
  import rpbu_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] out_red;
  logic [ChanW-1:0] out_green;
  logic [ChanW-1:0] out_blue;
  logic             written;
  logic             row_end_out;

  modport source (
    output valid, out_red, out_green, out_blue, written, row_end_out,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, written, row_end_out,
    output ready
  );
endinterface

// ===== rtl/core/rpbu_cfg_if.sv =====
// ----------------------------------------------------------------------------
// rpbu_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and the data to write.
// ----------------------------------------------------------------------------
interface rpbu_cfg_if
  import rpbu_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== rtl/core/rpbu_alpha.sv =====
// ----------------------------------------------------------------------------
// rpbu_alpha: alpha path of the blend pipeline
// Selects the effective alpha; the first stage applies the tint alpha and sets
// the skip flag, the second derives the opaque flag for the merge stage.
// ----------------------------------------------------------------------------
module rpbu_alpha
  import rpbu_pkg::*;
(
  input  logic             clk_i,
  input  pipe_en_t         en_i,
  input  logic             coloring_only_i,
  input  logic             tint_act_i,
  input  logic [ChanW-1:0] tint_alpha_i,
  input  logic [ChanW-1:0] src_alpha_i,
  input  logic             row_end_i,
  output logic [ChanW-1:0] alpha1_o,
  output pix_flags_t       flags_o
);

  logic [ChanW-1:0]   alpha_raw;
  logic [2*ChanW-1:0] alpha_prod;
  logic [ChanW-1:0]   alpha1_d, alpha1_q;
  logic               skip1_q, row_end1_q;
  pix_flags_t         flags2_q;

  // Effective alpha before and after the tint.
  assign alpha_raw  = coloring_only_i ? ChanMax : src_alpha_i;
  assign alpha_prod = (2*ChanW)'(alpha_raw) * (2*ChanW)'(tint_alpha_i);
  assign alpha1_d   = tint_act_i ? alpha_prod[2*ChanW-1:ChanW] : alpha_raw;

  // Stage one: tinted alpha and the zero-alpha skip flag.
  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      alpha1_q   <= alpha1_d;
      skip1_q    <= (alpha_raw == '0);
      row_end1_q <= row_end_i;
    end
  end

  // Stage two: the opaque decision travels with the flags.
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      flags2_q.skip    <= skip1_q;
      flags2_q.opaque  <= (alpha1_q == ChanMax);
      flags2_q.row_end <= row_end1_q;
    end
  end

  assign alpha1_o = alpha1_q;
  assign flags_o  = flags2_q;

endmodule

// ===== rtl/core/rpbu_lane.sv =====
// ----------------------------------------------------------------------------
// rpbu_lane: one color channel of the blender
// Stage one applies the tint, stage two forms both weighted products, and
// the combine logic after stage two applies the blend operation and clamps.
// ----------------------------------------------------------------------------
module rpbu_lane
  import rpbu_pkg::*;
(
  input  logic             clk_i,
  input  pipe_en_t         en_i,
  input  lane_ctl_t        ctl_i,
  input  logic [ChanW-1:0] tint_i,
  input  logic [ChanW-1:0] alpha1_i,
  input  logic [ChanW-1:0] src_i,
  input  logic [ChanW-1:0] dst_i,
  output logic [ChanW-1:0] src_o,
  output logic [ChanW-1:0] dst_o,
  output logic [ChanW-1:0] res_o
);

  logic [2*ChanW-1:0] tint_prod;
  logic [ChanW-1:0]   src1_d, src1_q, dst1_q;
  logic [ChanW-1:0]   src2_q, dst2_q;
  logic [ChanW-1:0]   sf, df;
  logic [2*ChanW-1:0] ps_d, pd_d, ps_q, pd_q;
  logic [2*ChanW:0]   sum;
  logic [2*ChanW-1:0] diff_sd, diff_ds;

  // Weight selection for one channel; unused codes give full scale.
  function automatic logic [ChanW-1:0] pick_factor(
    input factor_e          sel,
    input logic [ChanW-1:0] alpha,
    input logic [ChanW-1:0] s,
    input logic [ChanW-1:0] d
  );
    logic [ChanW-1:0] f;
    case (sel)
      FacZero:        f = '0;
      FacOne:         f = ChanMax;
      FacSrcAlpha:    f = alpha;
      FacInvSrcAlpha: f = ChanMax - alpha;
      FacDstAlpha:    f = ChanMax;
      FacInvDstAlpha: f = '0;
      FacSrcColor:    f = s;
      FacDstColor:    f = d;
      FacInvSrcColor: f = ChanMax - s;
      FacInvDstColor: f = ChanMax - d;
      default:        f = ChanMax;
    endcase
    return f;
  endfunction

  // Stage one: tint the source channel.
  assign tint_prod = (2*ChanW)'(src_i) * (2*ChanW)'(tint_i);
  assign src1_d    = ctl_i.tint_act ? tint_prod[2*ChanW-1:ChanW] : src_i;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      src1_q <= src1_d;
      dst1_q <= dst_i;
    end
  end

  // Stage two: weighted source and destination products.
  assign sf   = pick_factor(ctl_i.src_factor, alpha1_i, src1_q, dst1_q);
  assign df   = pick_factor(ctl_i.dst_factor, alpha1_i, src1_q, dst1_q);
  assign ps_d = (2*ChanW)'(src1_q) * (2*ChanW)'(sf);
  assign pd_d = (2*ChanW)'(dst1_q) * (2*ChanW)'(df);

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      ps_q   <= ps_d;
      pd_q   <= pd_d;
      src2_q <= src1_q;
      dst2_q <= dst1_q;
    end
  end

  // Combine the products, scale down by 256 and clamp to the channel range.
  assign sum     = (2*ChanW+1)'(ps_q) + (2*ChanW+1)'(pd_q);
  assign diff_sd = ps_q - pd_q;
  assign diff_ds = pd_q - ps_q;

  always_comb begin
    case (ctl_i.blend_op)
      OpAdd:    res_o = sum[2*ChanW] ? ChanMax : sum[2*ChanW-1:ChanW];
      OpSub:    res_o = (ps_q > pd_q) ? diff_sd[2*ChanW-1:ChanW] : '0;
      OpRevSub: res_o = (pd_q > ps_q) ? diff_ds[2*ChanW-1:ChanW] : '0;
      OpAnd:    res_o = ps_q[2*ChanW-1:ChanW] & pd_q[2*ChanW-1:ChanW];
      default:  res_o = dst2_q;
    endcase
  end

  assign src_o = src2_q;
  assign dst_o = dst2_q;

endmodule

// ===== rtl/core/rpbu_merge.sv =====
// ----------------------------------------------------------------------------
// rpbu_merge: output stage of the blender
// Chooses per pixel between the untouched destination, the opaque source and
// the blended lane results, and holds the transaction in the output register.
// ----------------------------------------------------------------------------
module rpbu_merge
  import rpbu_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           load_i,
  input  pix_flags_t                     flags_i,
  input  logic [NumLanes-1:0][ChanW-1:0] src_i,
  input  logic [NumLanes-1:0][ChanW-1:0] dst_i,
  input  logic [NumLanes-1:0][ChanW-1:0] res_i,
  output logic [NumLanes-1:0][ChanW-1:0] chan_o,
  output logic                           written_o,
  output logic                           row_end_o
);

  logic [NumLanes-1:0][ChanW-1:0] chan_d, chan_q;
  logic                           written_q, row_end_q;

  // Select the final value of each channel.
  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      if (flags_i.skip) begin
        chan_d[i] = dst_i[i];
      end else if (flags_i.opaque) begin
        chan_d[i] = src_i[i];
      end else begin
        chan_d[i] = res_i[i];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      chan_q    <= chan_d;
      written_q <= !flags_i.skip;
      row_end_q <= flags_i.row_end;
    end
  end

  assign chan_o    = chan_q;
  assign written_o = written_q;
  assign row_end_o = row_end_q;

endmodule

// ===== rtl/core/rgb24_pixel_blend_unit_core.sv =====
// ----------------------------------------------------------------------------
// rgb24_pixel_blend_unit_core: RGB24 pixel blender
// Three-stage pipeline with one lane per color channel and a merge stage.
// ----------------------------------------------------------------------------
// The blender takes one pixel transaction per clock and returns one result
// transaction per pixel, in order: stage one applies the tint (one 8x8
// multiply per channel and one for alpha), stage two forms the source and
// destination products (two 8x8 multiplies per lane), and the merge stage
// blends, clamps and loads the output register. Each stage holds its
// transaction only while the stage after it is full, so the input stays
// ready while a result waits in the output register and fills in bubbles;
// throughput drops below one pixel per clock only while the sink holds ready
// low. Configuration writes are always taken and must be issued only while
// no pixel is in flight.
module rgb24_pixel_blend_unit_core
  import rpbu_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  rpbu_pix_in_if.sink    pix_in,
  rpbu_pix_out_if.source pix_out,
  rpbu_cfg_if.sink       cfg
);

  // Configuration registers.
  factor_e        src_factor_q, dst_factor_q;
  blend_op_e      blend_op_q;
  logic           coloring_only_q, tint_enable_q;
  logic [ChanW-1:0] tint_alpha_q;
  logic [3*ChanW-1:0] tint_rgb_q;

  // Pipeline control.
  logic     v1_q, v2_q, vout_q;
  logic     v1_d, v2_d, vout_d;
  logic     en1, en2, en3;
  pipe_en_t pipe_en;
  lane_ctl_t lane_ctl;

  // Lane data.
  logic [NumLanes-1:0][ChanW-1:0] src_in, dst_in, tint_in;
  logic [NumLanes-1:0][ChanW-1:0] lane_src, lane_dst, lane_res, chan_out;
  logic [ChanW-1:0]               alpha1;
  pix_flags_t                     flags;

  // Configuration writes.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_factor_q    <= FacOne;
      dst_factor_q    <= FacInvSrcAlpha;
      blend_op_q      <= OpAdd;
      coloring_only_q <= 1'b0;
      tint_enable_q   <= 1'b0;
      tint_alpha_q    <= '0;
      tint_rgb_q      <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_idx_e'(cfg.index))
        RegSrcFactor:    src_factor_q    <= factor_e'(cfg.data[3:0]);
        RegDstFactor:    dst_factor_q    <= factor_e'(cfg.data[3:0]);
        RegBlendOp:      blend_op_q      <= blend_op_e'(cfg.data[2:0]);
        RegColoringOnly: coloring_only_q <= cfg.data[0];
        RegTintEnable:   tint_enable_q   <= cfg.data[0];
        RegTintAlpha:    tint_alpha_q    <= cfg.data[ChanW-1:0];
        RegTintRgb:      tint_rgb_q      <= cfg.data[3*ChanW-1:0];
        default:         ;
      endcase
    end
  end

  // Stage enables: a stage loads when it is empty or its successor loads.
  assign en3 = !vout_q || pix_out.ready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign pix_in.ready = en1;
  assign pix_out.valid = vout_q;

  assign v1_d   = en1 ? pix_in.valid : v1_q;
  assign v2_d   = en2 ? v1_q : v2_q;
  assign vout_d = en3 ? v2_q : vout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      v1_q   <= v1_d;
      v2_q   <= v2_d;
      vout_q <= vout_d;
    end
  end

  assign pipe_en.s1 = en1;
  assign pipe_en.s2 = en2;

  // Control shared by the lanes.
  assign lane_ctl.tint_act   = tint_enable_q && (tint_alpha_q != '0);
  assign lane_ctl.src_factor = src_factor_q;
  assign lane_ctl.dst_factor = dst_factor_q;
  assign lane_ctl.blend_op   = blend_op_q;

  // Lane 0 is red, lane 1 green, lane 2 blue.
  assign src_in  = {pix_in.src_blue, pix_in.src_green, pix_in.src_red};
  assign dst_in  = {pix_in.dst_blue, pix_in.dst_green, pix_in.dst_red};
  assign tint_in = {tint_rgb_q[ChanW-1:0], tint_rgb_q[2*ChanW-1:ChanW],
                    tint_rgb_q[3*ChanW-1:2*ChanW]};

  rpbu_alpha u_alpha (
    .clk_i           (clk_i),
    .en_i            (pipe_en),
    .coloring_only_i (coloring_only_q),
    .tint_act_i      (lane_ctl.tint_act),
    .tint_alpha_i    (tint_alpha_q),
    .src_alpha_i     (pix_in.src_alpha),
    .row_end_i       (pix_in.row_end),
    .alpha1_o        (alpha1),
    .flags_o         (flags)
  );

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    rpbu_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (pipe_en),
      .ctl_i    (lane_ctl),
      .tint_i   (tint_in[g]),
      .alpha1_i (alpha1),
      .src_i    (src_in[g]),
      .dst_i    (dst_in[g]),
      .src_o    (lane_src[g]),
      .dst_o    (lane_dst[g]),
      .res_o    (lane_res[g])
    );
  end

  rpbu_merge u_merge (
    .clk_i     (clk_i),
    .load_i    (en3),
    .flags_i   (flags),
    .src_i     (lane_src),
    .dst_i     (lane_dst),
    .res_i     (lane_res),
    .chan_o    (chan_out),
    .written_o (pix_out.written),
    .row_end_o (pix_out.row_end_out)
  );

  assign pix_out.out_red   = chan_out[0];
  assign pix_out.out_green = chan_out[1];
  assign pix_out.out_blue  = chan_out[2];

  // A pixel in stage one that cannot advance stays there.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && !en2 |=> v1_q)
    else $error("stage one lost a pixel while stalled");

  // A pixel leaving stage one arrives in stage two.
  a_s1_to_s2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && en2 |=> v2_q)
    else $error("pixel dropped between stage one and stage two");

  // A pixel leaving stage two shows up at the output.
  a_s2_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && en3 |=> pix_out.valid)
    else $error("pixel dropped between stage two and the output register");

  // An empty pipeline never presents a result.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v2_q && pix_out.valid && pix_out.ready |=> !pix_out.valid)
    else $error("output presented a result with no pixel behind it");

endmodule

// ===== verif/rgb24_pixel_blend_unit_core_tb.sv =====
// ----------------------------------------------------------------------------
// rgb24_pixel_blend_unit_core_tb: self-checking bench of the pixel blender
// Streams pixel transactions under a series of blend settings and compares
// every result transaction with a software blend computed at acceptance.
// Both channel ends idle and stall at random, phase by phase.
// ----------------------------------------------------------------------------
module rgb24_pixel_blend_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rpbu_pkg::*;

  // Codes that the package leaves without a name.
  localparam logic [2:0] OpKeepDst    = 3'd5;
  localparam logic [2:0] OpKeepDstTop = 3'd7;
  localparam logic [3:0] FacFull      = 4'd12;
  localparam logic [3:0] FacFullTop   = 4'd15;

  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [ChanW-1:0] src_r;
    logic [ChanW-1:0] src_g;
    logic [ChanW-1:0] src_b;
    logic [ChanW-1:0] src_a;
    logic [ChanW-1:0] dst_r;
    logic [ChanW-1:0] dst_g;
    logic [ChanW-1:0] dst_b;
    logic             row_end;
  } pixel_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             written;
    logic             row_end;
  } blend_res_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  rpbu_pix_in_if  pix_in_ch ();
  rpbu_pix_out_if pix_out_ch ();
  rpbu_cfg_if     cfg_ch ();

  rgb24_pixel_blend_unit_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_in  (pix_in_ch),
    .pix_out (pix_out_ch),
    .cfg     (cfg_ch)
  );

  // Local copy of the blend settings, updated on each register transaction.
  logic [3:0]  set_src_fac;
  logic [3:0]  set_dst_fac;
  logic [2:0]  set_op;
  logic        set_coloring;
  logic        set_tint_en;
  logic [7:0]  set_tint_a;
  logic [23:0] set_tint_rgb;

  pixel_t     pixel_q[$];
  blend_res_t blend_q[$];
  pixel_t     cur_pix;

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned n_queued = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;
  int unsigned cycles = 0;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Known levels on every bench-driven signal from time zero.
  initial begin
    pix_in_ch.valid     = 1'b0;
    pix_in_ch.src_red   = '0;
    pix_in_ch.src_green = '0;
    pix_in_ch.src_blue  = '0;
    pix_in_ch.src_alpha = '0;
    pix_in_ch.dst_red   = '0;
    pix_in_ch.dst_green = '0;
    pix_in_ch.dst_blue  = '0;
    pix_in_ch.row_end   = 1'b0;
    pix_out_ch.ready    = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = RegSrcFactor;
    cfg_ch.data         = '0;
  end

  // Weight chosen by a factor selector.
  function automatic int unsigned pick_weight(logic [3:0] sel, int unsigned a,
                                              int unsigned s, int unsigned d);
    case (sel)
      FacZero:        return 0;
      FacOne:         return 255;
      FacSrcAlpha:    return a;
      FacInvSrcAlpha: return 255 - a;
      FacDstAlpha:    return 255;
      FacInvDstAlpha: return 0;
      FacSrcColor:    return s;
      FacDstColor:    return d;
      FacInvSrcColor: return 255 - s;
      FacInvDstColor: return 255 - d;
      default:        return 255;
    endcase
  endfunction

  // New destination color for one pixel under the current settings.
  function automatic blend_res_t blend_pixel(pixel_t p);
    int unsigned s[3];
    int unsigned d[3];
    int unsigned t[3];
    int unsigned r[3];
    int unsigned a, ps, pd, sum;
    int i;
    blend_res_t res;
    s[0] = p.src_r;  s[1] = p.src_g;  s[2] = p.src_b;
    d[0] = p.dst_r;  d[1] = p.dst_g;  d[2] = p.dst_b;
    t[0] = set_tint_rgb[23:16];
    t[1] = set_tint_rgb[15:8];
    t[2] = set_tint_rgb[7:0];
    a = set_coloring ? 255 : p.src_a;
    res.row_end = p.row_end;
    // Transparent source: the destination stays as it is.
    if (a == 0) begin
      res.red     = p.dst_r;
      res.green   = p.dst_g;
      res.blue    = p.dst_b;
      res.written = 1'b0;
      return res;
    end
    if (set_tint_en && set_tint_a != 0) begin
      for (i = 0; i < 3; i++) s[i] = (s[i] * t[i]) >> 8;
      a = (a * set_tint_a) >> 8;
    end
    for (i = 0; i < 3; i++) begin
      if (a == 255) begin
        r[i] = s[i];
      end else begin
        ps = s[i] * pick_weight(set_src_fac, a, s[i], d[i]);
        pd = d[i] * pick_weight(set_dst_fac, a, s[i], d[i]);
        case (set_op)
          OpAdd: begin
            sum  = (ps + pd) >> 8;
            r[i] = (sum > 255) ? 255 : sum;
          end
          OpSub:    r[i] = (ps > pd) ? ((ps - pd) >> 8) : 0;
          OpRevSub: r[i] = (pd > ps) ? ((pd - ps) >> 8) : 0;
          OpAnd:    r[i] = (ps & pd) >> 8;
          default:  r[i] = d[i];
        endcase
      end
    end
    res.red     = ChanW'(r[0]);
    res.green   = ChanW'(r[1]);
    res.blue    = ChanW'(r[2]);
    res.written = 1'b1;
    return res;
  endfunction

  // Pixel driver: presents queued pixels and records the expected blend of
  // each accepted transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_in_ch.valid <= 1'b0;
    end else begin
      if (pix_in_ch.valid && pix_in_ch.ready) begin
        blend_q.push_back(blend_pixel(cur_pix));
      end
      if (!pix_in_ch.valid || pix_in_ch.ready) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_pix = pixel_q.pop_front();
          pix_in_ch.valid     <= 1'b1;
          pix_in_ch.src_red   <= cur_pix.src_r;
          pix_in_ch.src_green <= cur_pix.src_g;
          pix_in_ch.src_blue  <= cur_pix.src_b;
          pix_in_ch.src_alpha <= cur_pix.src_a;
          pix_in_ch.dst_red   <= cur_pix.dst_r;
          pix_in_ch.dst_green <= cur_pix.dst_g;
          pix_in_ch.dst_blue  <= cur_pix.dst_b;
          pix_in_ch.row_end   <= cur_pix.row_end;
        end else begin
          pix_in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      n_errors++;
      $display("[%0t] result %0d %s mismatch: expected %0h, actual %0h",
               $time, n_results, name, want, got);
    end
  endtask

  // Result monitor: random back-pressure and field-by-field comparison.
  always @(posedge clk_i or negedge rst_ni) begin
    blend_res_t want;
    if (!rst_ni) begin
      pix_out_ch.ready <= 1'b0;
    end else begin
      if (pix_out_ch.valid && pix_out_ch.ready) begin
        n_results++;
        if (blend_q.size() == 0) begin
          n_errors++;
          $display("[%0t] result transaction with no pixel pending: %0h %0h %0h",
                   $time, pix_out_ch.out_red, pix_out_ch.out_green,
                   pix_out_ch.out_blue);
        end else begin
          want = blend_q.pop_front();
          check_field("out_red", want.red, pix_out_ch.out_red);
          check_field("out_green", want.green, pix_out_ch.out_green);
          check_field("out_blue", want.blue, pix_out_ch.out_blue);
          check_field("written", 8'(want.written), 8'(pix_out_ch.written));
          check_field("row_end_out", 8'(want.row_end), 8'(pix_out_ch.row_end_out));
        end
      end
      pix_out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_pixel(logic [7:0] sr, logic [7:0] sg, logic [7:0] sb,
                            logic [7:0] sa, logic [7:0] dr, logic [7:0] dg,
                            logic [7:0] db, logic re);
    pixel_q.push_back('{sr, sg, sb, sa, dr, dg, db, re});
    n_queued++;
  endtask

  // Biased channel value: the extremes come up often.
  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic push_random_pixel();
    push_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(),
               rand_chan(), rand_chan(), rand_chan(), 1'($urandom_range(1)));
  endtask

  // Waits until every queued pixel has come back, then lets the pipe settle.
  // Returns right after a rising edge.
  task automatic drain();
    do @(posedge clk_i); while (n_results < n_queued);
    repeat (4) @(posedge clk_i);
  endtask

  // One register transaction; valid is left high for a following write.
  task automatic cfg_write(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      RegSrcFactor:    set_src_fac  = value[3:0];
      RegDstFactor:    set_dst_fac  = value[3:0];
      RegBlendOp:      set_op       = value[2:0];
      RegColoringOnly: set_coloring = value[0];
      RegTintEnable:   set_tint_en  = value[0];
      RegTintAlpha:    set_tint_a   = value[7:0];
      RegTintRgb:      set_tint_rgb = value[23:0];
      default: ;
    endcase
  endtask

  // Drains the pipe and loads a complete blend setting.
  task automatic set_blend(logic [3:0] sf, logic [3:0] df, logic [2:0] op,
                           logic co, logic te, logic [7:0] ta, logic [23:0] trgb);
    drain();
    cfg_write(RegSrcFactor, CfgDataW'(sf));
    cfg_write(RegDstFactor, CfgDataW'(df));
    cfg_write(RegBlendOp, CfgDataW'(op));
    cfg_write(RegColoringOnly, CfgDataW'(co));
    cfg_write(RegTintEnable, CfgDataW'(te));
    cfg_write(RegTintAlpha, CfgDataW'(ta));
    cfg_write(RegTintRgb, trgb);
    cfg_ch.valid <= 1'b0;
  endtask

  // Stimulus and end of test.
  initial begin
    int ph, k;
    set_src_fac  = FacOne;
    set_dst_fac  = FacInvSrcAlpha;
    set_op       = OpAdd;
    set_coloring = 1'b0;
    set_tint_en  = 1'b0;
    set_tint_a   = 8'h00;
    set_tint_rgb = 24'h000000;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Settings after reset: transparent, opaque, saturating add, edge alphas.
    push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 8'h80, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'h0A, 8'hC8, 8'h5A, 8'h01, 8'hFF, 8'h00, 8'h80, 1'b1);
    push_pixel(8'hFF, 8'h00, 8'hFF, 8'hFE, 8'h00, 8'hFF, 8'h00, 1'b0);

    // Subtract in both directions, with negative differences clamped.
    set_blend(FacOne, FacOne, OpSub, 1'b0, 1'b0, 8'h00, 24'h000000);
    push_pixel(8'h0A, 8'h0A, 8'h0A, 8'h64, 8'hC8, 8'hC8, 8'hC8, 1'b0);
    push_pixel(8'hC8, 8'hC8, 8'hC8, 8'h64, 8'h0A, 8'h0A, 8'h0A, 1'b1);
    set_blend(FacOne, FacOne, OpRevSub, 1'b0, 1'b0, 8'h00, 24'h000000);
    push_pixel(8'h0A, 8'h0A, 8'h0A, 8'h64, 8'hC8, 8'hC8, 8'hC8, 1'b0);
    push_pixel(8'hC8, 8'hC8, 8'hC8, 8'h64, 8'h0A, 8'h0A, 8'h0A, 1'b1);

    // AND of the products.
    set_blend(FacSrcColor, FacDstColor, OpAnd, 1'b0, 1'b0, 8'h00, 24'h000000);
    push_pixel(8'hFF, 8'hAA, 8'h55, 8'h4D, 8'hFF, 8'h55, 8'hAA, 1'b0);
    push_pixel(8'h7F, 8'h80, 8'h01, 8'hFE, 8'h80, 8'h7F, 8'hFE, 1'b1);

    // Unused operation keeps the destination, but an opaque pixel is written.
    set_blend(FacFull, FacFullTop, OpKeepDst, 1'b0, 1'b0, 8'h00, 24'h000000);
    push_pixel(8'h12, 8'h34, 8'h56, 8'h64, 8'h9A, 8'hBC, 8'hDE, 1'b0);
    push_pixel(8'h12, 8'h34, 8'h56, 8'hFF, 8'h9A, 8'hBC, 8'hDE, 1'b1);

    // Coloring only: source alpha of zero is ignored.
    set_blend(FacSrcAlpha, FacInvSrcAlpha, OpAdd, 1'b1, 1'b0, 8'h00, 24'h000000);
    push_pixel(8'h01, 8'h02, 8'h03, 8'h00, 8'h04, 8'h05, 8'h06, 1'b0);

    // Tint that brings alpha down to zero: still blended and written.
    set_blend(FacSrcAlpha, FacInvSrcAlpha, OpAdd, 1'b0, 1'b1, 8'h01, 24'hFFFFFF);
    push_pixel(8'hFF, 8'h80, 8'h01, 8'h01, 8'h11, 8'h22, 8'h33, 1'b0);
    push_pixel(8'hFF, 8'h80, 8'h01, 8'hFF, 8'h11, 8'h22, 8'h33, 1'b1);

    // Tint enabled with zero tint alpha does nothing; full tint alpha does.
    set_blend(FacSrcAlpha, FacInvSrcAlpha, OpAdd, 1'b0, 1'b1, 8'h00, 24'h80FF00);
    push_pixel(8'hC0, 8'hC0, 8'hC0, 8'hFF, 8'h40, 8'h40, 8'h40, 1'b0);
    set_blend(FacSrcAlpha, FacInvSrcAlpha, OpAdd, 1'b0, 1'b1, 8'hFF, 24'h80FF00);
    push_pixel(8'hC0, 8'hC0, 8'hC0, 8'hFF, 8'h40, 8'h40, 8'h40, 1'b1);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 8'h80, 8'hFF, 8'hFF, 8'hFF, 1'b0);

    // Random part: a new setting and handshake pattern per phase.
    for (ph = 0; ph < 16; ph++) begin
      if (ph == 0) begin
        set_blend(FacFullTop, FacFullTop, OpKeepDstTop, 1'b1, 1'b1, 8'hFF, 24'hFFFFFF);
      end else if (ph == 1) begin
        set_blend(FacZero, FacZero, OpAdd, 1'b0, 1'b0, 8'h00, 24'h000000);
      end else begin
        set_blend(4'($urandom_range(15)), 4'($urandom_range(15)),
                  3'($urandom_range(7)), ($urandom_range(4) == 0),
                  1'($urandom_range(1)), rand_chan(),
                  {rand_chan(), rand_chan(), rand_chan()});
      end
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 65; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 65; end
        default: begin src_idle_pct = 14; snk_stall_pct = 14; end
      endcase
      for (k = 0; k < 50; k++) begin
        // Once, hold the stream back until the pipe is empty.
        if (ph == 6 && k == 25) begin
          do @(posedge clk_i); while (n_results < n_queued);
        end
        push_random_pixel();
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (blend_q.size() != 0) begin
      n_errors++;
      $display("[%0t] %0d expected results never arrived", $time, blend_q.size());
    end
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
